FILE: rtl/core/gutter_column_grouper_macros.svh
// Assertion macros shared by the gutter column grouper RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef GUTTER_COLUMN_GROUPER_MACROS_SVH
`define GUTTER_COLUMN_GROUPER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define GCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gcg_pkg.sv
// Package for the gutter column grouper: constants, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gcg_pkg;

  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned CFG_W           = 8;
  localparam int unsigned DEF_MAX_GUTTERS = 64;
  localparam int unsigned DEF_COORD_BITS  = 16;

  localparam logic [CFG_W-1:0] SHRINK_X_RST = 8'd10;
  localparam logic [CFG_W-1:0] SHRINK_Y_RST = 8'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_LINE = 2'd1,
    OP_EOP  = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    REG_SHRINK_X = 1'b0,
    REG_SHRINK_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load;    // store gutter from input request
    logic latch;   // capture line box from input request
    logic first;   // first line of page
    logic merge;   // grow region, start scan
    logic scan;    // step gutter scan
    logic decide;  // split or join column
    logic flush;   // end of page
  } cmd_t;

  typedef struct packed {
    logic line_seen;
    logic hit;
    logic done;
    logic split;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/gcg_ctrl.sv
// Controller FSM of the gutter column grouper.
// Depends on gcg_pkg and gutter_column_grouper_macros.svh.
`default_nettype none
`include "gutter_column_grouper_macros.svh"

module gcg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_op_i,
  output logic                  in_ready_o,
  input  wire gcg_pkg::status_t status_i,
  output gcg_pkg::cmd_t         cmd_o
);
  import gcg_pkg::*;

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(in_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_LINE: state_d = ST_LINE;
            OP_EOP:  state_d = ST_FLUSH;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LINE: begin
        state_d = status_i.line_seen ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status_i.split || status_i.out_free) state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (!status_i.line_seen || status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i && (op == OP_LOAD);
        cmd_o.latch = in_valid_i && (op == OP_LINE);
      end
      ST_LINE: begin
        cmd_o.first = !status_i.line_seen;
        cmd_o.merge = status_i.line_seen;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.decide = !status_i.split || status_i.out_free;
      end
      ST_FLUSH: begin
        cmd_o.flush = !status_i.line_seen || status_i.out_free;
      end
      default: ;
    endcase
  end

  `GCG_ASSERT(a_decide_after_scan, (state_q == ST_DECIDE) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_DECIDE), "decide entered without scan")
  `GCG_ASSERT_NEXT(a_scan_after_merge, cmd_o.merge, state_q == ST_SCAN, "merge not followed by scan")
  `GCG_ASSERT(a_ready_only_idle, in_ready_o |-> (cmd_o.scan == 1'b0 && cmd_o.decide == 1'b0), "request taken while busy")

endmodule

`default_nettype wire

FILE: rtl/core/gcg_datapath.sv
// Datapath of the gutter column grouper: config registers, gutter table,
// line/column/region registers, scan compare and output register. Depends on gcg_pkg.
`default_nettype none
`include "gutter_column_grouper_macros.svh"

module gcg_datapath #(
  parameter int unsigned MAX_GUTTERS = gcg_pkg::DEF_MAX_GUTTERS,
  parameter int unsigned COORD_BITS  = gcg_pkg::DEF_COORD_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gcg_pkg::cmd_t               cmd_i,
  output gcg_pkg::status_t                 status_o,
  input  wire logic [4*gcg_pkg::FIELD_W-1:0] in_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_index_i,
  input  wire logic [gcg_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [4*gcg_pkg::FIELD_W-1:0]    out_data_o,
  output logic                             out_last_o
);
  import gcg_pkg::*;

  localparam int unsigned VW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned SW   = VW + 2;
  localparam int unsigned AW   = (MAX_GUTTERS > 1) ? $clog2(MAX_GUTTERS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_GUTTERS + 1);

  logic [CFG_W-1:0] shrink_x_q, shrink_y_q;

  logic [4*VW-1:0] gutter_mem_q [MAX_GUTTERS];
  logic [4*VW-1:0] rdata_q;
  logic [CNTW-1:0] count_q, rd_idx_q;
  logic            rd_valid_q;
  logic            rd_issue;

  logic [VW-1:0] bx0_q, by0_q, bx1_q, by1_q;
  logic [VW-1:0] cx0_q, cy0_q, cx1_q, cy1_q;
  logic signed [SW-1:0] rx0_q, ry0_q, rx1_q, ry1_q;
  logic signed [SW-1:0] sx0, sy0, sx1, sy1;
  logic          region_empty_q, line_seen_q;
  logic          hit_q, below_q, above_q;

  logic [VW-1:0] gx0, gy0, gx1, gy1, xc;
  logic signed [SW-1:0] sgx0, sgy0, sgx1, sgy1;
  logic          ovl, hit, from_below, from_above, split, out_free, emit;

  logic                     out_valid_q, out_last_q;
  logic [4*FIELD_W-1:0]     out_data_q;

  // shrunk line box
  assign sx0 = SW'(bx0_q) + SW'(shrink_x_q);
  assign sx1 = SW'(bx1_q) - SW'(shrink_x_q);
  assign sy0 = SW'(by0_q) + SW'(shrink_y_q);
  assign sy1 = SW'(by1_q) - SW'(shrink_y_q);

  // gutter entry under compare
  assign gx0  = rdata_q[VW-1:0];
  assign gy0  = rdata_q[2*VW-1:VW];
  assign gx1  = rdata_q[3*VW-1:2*VW];
  assign gy1  = rdata_q[4*VW-1:3*VW];
  assign sgx0 = $signed(SW'(gx0));
  assign sgy0 = $signed(SW'(gy0));
  assign sgx1 = $signed(SW'(gx1));
  assign sgy1 = $signed(SW'(gy1));
  assign xc   = VW'(((VW+1)'(gx0) + (VW+1)'(gx1)) >> 1);

  assign ovl = (rx0_q < rx1_q) && (ry0_q < ry1_q) && (gx0 < gx1) && (gy0 < gy1) &&
               (rx0_q < sgx1) && (sgx0 < rx1_q) && (ry0_q < sgy1) && (sgy0 < ry1_q);
  assign from_below = (bx0_q <= xc) && (xc < bx1_q) && (by0_q <= gy1) && (gy1 < by1_q);
  assign from_above = (bx0_q <= xc) && (xc < bx1_q) && (by0_q <= gy0) && (gy0 < by1_q);

  assign rd_issue = cmd_i.scan && (rd_idx_q < count_q);
  assign hit      = rd_valid_q && ovl;
  assign split    = hit_q && !below_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (cmd_i.decide && split) || (cmd_i.flush && line_seen_q);

  assign status_o.line_seen = line_seen_q;
  assign status_o.hit       = hit;
  assign status_o.done      = !rd_issue && !rd_valid_q;
  assign status_o.split     = split;
  assign status_o.out_free  = out_free;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shrink_x_q <= SHRINK_X_RST;
      shrink_y_q <= SHRINK_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SHRINK_X: shrink_x_q <= cfg_data_i;
        REG_SHRINK_Y: shrink_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gutter table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CNTW'(MAX_GUTTERS))) begin
      gutter_mem_q[count_q[AW-1:0]] <= {in_data_i[3*FIELD_W +: VW], in_data_i[2*FIELD_W +: VW],
                                        in_data_i[FIELD_W +: VW], in_data_i[0 +: VW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rdata_q <= gutter_mem_q[rd_idx_q[AW-1:0]];
    end
  end

  // line box
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      bx0_q <= in_data_i[0 +: VW];
      by0_q <= in_data_i[FIELD_W +: VW];
      bx1_q <= in_data_i[2*FIELD_W +: VW];
      by1_q <= in_data_i[3*FIELD_W +: VW];
    end
  end

  // page state and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      rd_idx_q       <= '0;
      rd_valid_q     <= 1'b0;
      hit_q          <= 1'b0;
      below_q        <= 1'b0;
      above_q        <= 1'b0;
      cx0_q          <= '0;
      cy0_q          <= '0;
      cx1_q          <= '0;
      cy1_q          <= '0;
      rx0_q          <= '0;
      ry0_q          <= '0;
      rx1_q          <= '0;
      ry1_q          <= '0;
      region_empty_q <= 1'b1;
      line_seen_q    <= 1'b0;
    end else begin
      if (cmd_i.load && (count_q < CNTW'(MAX_GUTTERS))) begin
        count_q <= count_q + CNTW'(1);
      end

      if (cmd_i.first) begin
        line_seen_q    <= 1'b1;
        cx0_q          <= bx0_q;
        cy0_q          <= by0_q;
        cx1_q          <= bx1_q;
        cy1_q          <= by1_q;
        rx0_q          <= sx0;
        ry0_q          <= sy0;
        rx1_q          <= sx1;
        ry1_q          <= sy1;
        region_empty_q <= 1'b0;
      end

      if (cmd_i.merge) begin
        rd_idx_q       <= '0;
        rd_valid_q     <= 1'b0;
        hit_q          <= 1'b0;
        region_empty_q <= 1'b0;
        if (region_empty_q) begin
          rx0_q <= sx0;
          ry0_q <= sy0;
          rx1_q <= sx1;
          ry1_q <= sy1;
        end else begin
          rx0_q <= (sx0 < rx0_q) ? sx0 : rx0_q;
          ry0_q <= (sy0 < ry0_q) ? sy0 : ry0_q;
          rx1_q <= (sx1 > rx1_q) ? sx1 : rx1_q;
          ry1_q <= (sy1 > ry1_q) ? sy1 : ry1_q;
        end
      end

      if (cmd_i.scan) begin
        rd_valid_q <= rd_issue;
        if (rd_issue) rd_idx_q <= rd_idx_q + CNTW'(1);
        if (hit) begin
          hit_q   <= 1'b1;
          below_q <= from_below;
          above_q <= from_above;
        end
      end

      if (cmd_i.decide) begin
        if (split) begin
          cx0_q <= bx0_q;
          cy0_q <= by0_q;
          cx1_q <= bx1_q;
          cy1_q <= by1_q;
          if (above_q) begin
            rx0_q          <= '0;
            ry0_q          <= '0;
            rx1_q          <= '0;
            ry1_q          <= '0;
            region_empty_q <= 1'b1;
          end else begin
            rx0_q          <= sx0;
            ry0_q          <= sy0;
            rx1_q          <= sx1;
            ry1_q          <= sy1;
            region_empty_q <= 1'b0;
          end
        end else begin
          cx0_q <= (bx0_q < cx0_q) ? bx0_q : cx0_q;
          cy0_q <= (by0_q < cy0_q) ? by0_q : cy0_q;
          cx1_q <= (bx1_q > cx1_q) ? bx1_q : cx1_q;
          cy1_q <= (by1_q > cy1_q) ? by1_q : cy1_q;
        end
      end

      if (cmd_i.flush) begin
        count_q        <= '0;
        cx0_q          <= '0;
        cy0_q          <= '0;
        cx1_q          <= '0;
        cy1_q          <= '0;
        rx0_q          <= '0;
        ry0_q          <= '0;
        rx1_q          <= '0;
        ry1_q          <= '0;
        region_empty_q <= 1'b1;
        line_seen_q    <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {FIELD_W'(cy1_q), FIELD_W'(cx1_q), FIELD_W'(cy0_q), FIELD_W'(cx0_q)};
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  `GCG_ASSERT(a_count_bound, count_q <= CNTW'(MAX_GUTTERS), "gutter count past table depth")
  `GCG_ASSERT(a_emit_free, emit |-> out_free, "result overwrites pending result")
  `GCG_ASSERT_NEXT(a_flush_clears, cmd_i.flush, !line_seen_q && count_q == '0, "page not cleared")

endmodule

`default_nettype wire

FILE: rtl/core/gutter_column_grouper.sv
// Gutter column grouper. Requests with tuser OP_LOAD store a gutter box (loads
// past the table depth are dropped), OP_LINE groups a text line and OP_EOP
// flushes the last column with tlast set and clears the page state. The first
// line of a page only opens the column. Any later line grows the region and scans
// the gutters in load order up to the first overlapping one (at most the
// loaded count), since the gutter table has one read port and one entry is
// compared per cycle; a line that closes a column also waits for a free output
// register. End of page waits for the output register when it emits a column.
// Output is registered; a new request is taken while a result waits. Uses
// gcg_pkg, gcg_ctrl and gcg_datapath.
`default_nettype none

module gutter_column_grouper #(
  parameter int unsigned MAX_GUTTERS = gcg_pkg::DEF_MAX_GUTTERS,
  parameter int unsigned COORD_BITS  = gcg_pkg::DEF_COORD_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // box_x0, box_y0, box_x1, box_y1
  input  wire logic [4*gcg_pkg::FIELD_W-1:0] s_axis_tdata,
  // op
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // col_x0, col_y0, col_x1, col_y1
  output logic [4*gcg_pkg::FIELD_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [0:0]                    cfg_index_i,
  input  wire logic [gcg_pkg::CFG_W-1:0]     cfg_data_i
);
  import gcg_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  gcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gcg_datapath #(
    .MAX_GUTTERS (MAX_GUTTERS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/sv/gutter_column_grouper_checker.sv
`timescale 1ns / 1ps
// Checker for gutter_column_grouper: follows the request, result and register channels,
// predicts every finished column and compares it with the output stream. Uses gcg_pkg.
module gutter_column_grouper_checker #(
  parameter int unsigned MAX_GUTTERS = gcg_pkg::DEF_MAX_GUTTERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // box_x0, box_y0, box_x1, box_y1
  input  logic [63:0] s_axis_tdata,
  // op
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // col_x0, col_y0, col_x1, col_y1
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned columns_o,
  output int unsigned page_ends_o
);
  import gcg_pkg::*;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } box_t;

  typedef struct {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        last;
  } column_t;

  box_t        gutters [MAX_GUTTERS];
  int unsigned n_gutters;
  box_t        column;
  box_t        region;
  bit          region_void;
  bit          line_seen;
  int unsigned shrink_x;
  int unsigned shrink_y;
  column_t     expected_cols [$];
  int unsigned errs;
  int unsigned columns;
  int unsigned page_ends;

  function automatic bit box_void(box_t b);
    return (b.x0 >= b.x1) || (b.y0 >= b.y1);
  endfunction

  function automatic bit box_has(box_t b, int x, int y);
    return (b.x0 <= x) && (x < b.x1) && (b.y0 <= y) && (y < b.y1);
  endfunction

  function automatic box_t box_grow(box_t acc, box_t b);
    box_t r;
    r = acc;
    if (b.x0 < r.x0) r.x0 = b.x0;
    if (b.y0 < r.y0) r.y0 = b.y0;
    if (b.x1 > r.x1) r.x1 = b.x1;
    if (b.y1 > r.y1) r.y1 = b.y1;
    return r;
  endfunction

  function automatic column_t column_of(box_t c, logic last);
    column_t r;
    r.x0   = 16'(c.x0);
    r.y0   = 16'(c.y0);
    r.x1   = 16'(c.x1);
    r.y1   = 16'(c.y1);
    r.last = last;
    return r;
  endfunction

  task automatic clear_page();
    n_gutters   = 0;
    column      = '{default: 0};
    region      = '{default: 0};
    region_void = 1'b1;
    line_seen   = 1'b0;
  endtask

  task automatic note_error(input string msg);
    errs++;
    if (errs <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic group_request(input logic [1:0] op, input logic [63:0] data);
    box_t b;
    box_t s;
    box_t g;
    bit   hit;
    bit   below;
    bit   above;
    int   xc;
    int   j;
    b.x0 = int'(data[15:0]);
    b.y0 = int'(data[31:16]);
    b.x1 = int'(data[47:32]);
    b.y1 = int'(data[63:48]);
    s.x0 = b.x0 + int'(shrink_x);
    s.x1 = b.x1 - int'(shrink_x);
    s.y0 = b.y0 + int'(shrink_y);
    s.y1 = b.y1 - int'(shrink_y);
    case (op)
      OP_LOAD: begin
        if (n_gutters < MAX_GUTTERS) begin
          gutters[n_gutters] = b;
          n_gutters++;
        end
      end
      OP_EOP: begin
        if (line_seen) expected_cols.push_back(column_of(column, 1'b1));
        clear_page();
      end
      OP_LINE: begin
        if (!line_seen) begin
          line_seen   = 1'b1;
          column      = b;
          region      = s;
          region_void = 1'b0;
        end else begin
          region      = region_void ? s : box_grow(region, s);
          region_void = 1'b0;
          hit   = 1'b0;
          below = 1'b0;
          above = 1'b0;
          // first overlapping gutter in load order decides
          for (j = 0; j < n_gutters; j++) begin
            g = gutters[j];
            if (!hit && !box_void(region) && !box_void(g) &&
                region.x0 < g.x1 && g.x0 < region.x1 &&
                region.y0 < g.y1 && g.y0 < region.y1) begin
              hit   = 1'b1;
              xc    = (g.x0 + g.x1) / 2;
              below = box_has(b, xc, g.y1);
              above = box_has(b, xc, g.y0);
            end
          end
          if (hit && !below) begin
            expected_cols.push_back(column_of(column, 1'b0));
            column = b;
            if (above) begin
              region      = '{default: 0};
              region_void = 1'b1;
            end else begin
              region = s;
            end
          end else begin
            column = box_grow(column, b);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_column();
    column_t want;
    if (expected_cols.size() == 0) begin
      note_error($sformatf("unexpected column (%0d,%0d,%0d,%0d) last=%0b",
                           m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                           m_axis_tdata[63:48], m_axis_tlast));
    end else begin
      want = expected_cols.pop_front();
      columns++;
      if (want.last) page_ends++;
      if (m_axis_tdata[15:0] !== want.x0 || m_axis_tdata[31:16] !== want.y0 ||
          m_axis_tdata[47:32] !== want.x1 || m_axis_tdata[63:48] !== want.y1 ||
          m_axis_tlast !== want.last)
        note_error($sformatf("column %0d: exp (%0d,%0d,%0d,%0d) last=%0b, got (%0d,%0d,%0d,%0d) last=%0b",
                             columns, want.x0, want.y0, want.x1, want.y1, want.last,
                             m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                             m_axis_tdata[63:48], m_axis_tlast));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_page();
      shrink_x = SHRINK_X_RST;
      shrink_y = SHRINK_Y_RST;
      expected_cols.delete();
      errs      = 0;
      columns   = 0;
      page_ends = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_SHRINK_X) shrink_x = cfg_data_i;
        else shrink_y = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) check_column();
      if (s_axis_tvalid && s_axis_tready) group_request(s_axis_tuser, s_axis_tdata);
    end
    err_count_o <= errs;
    pending_o   <= expected_cols.size();
    columns_o   <= columns;
    page_ends_o <= page_ends;
  end

endmodule

FILE: tb/sv/gutter_column_grouper_tb.sv
`timescale 1ns / 1ps
// Testbench top for gutter_column_grouper: drives gutter, line and page-end requests and
// the shrink registers, and gives the verdict. Needs gcg_pkg and the checker module.
module gutter_column_grouper_tb;
  import gcg_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 2 * DEF_MAX_GUTTERS + 20;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_REQS  = 90;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } rect_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  int unsigned errs;
  int unsigned pending;
  int unsigned columns;
  int unsigned page_ends;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned cycles         = 0;
  int unsigned reqs           = 0;
  int unsigned pages          = 0;
  rect_t       page_gutters [$];

  gutter_column_grouper u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  gutter_column_grouper_checker #(
    .MAX_GUTTERS(DEF_MAX_GUTTERS)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .err_count_o(errs),
    .pending_o  (pending),
    .columns_o  (columns),
    .page_ends_o(page_ends)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d columns still expected", cycles, pending);
      $display("FAIL gutter_column_grouper");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] clip(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return 16'(v);
  endfunction

  task automatic send_req(input logic [1:0] op, input rect_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {clip(r.y1), clip(r.x1), clip(r.y0), clip(r.x0)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    reqs++;
  endtask

  task automatic write_shrink(input logic [7:0] sx, input logic [7:0] sy);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_SHRINK_X;
    cfg_data_i  <= sx;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= REG_SHRINK_Y;
    cfg_data_i  <= sy;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_page();
    int    kind;
    int    n_g;
    int    n_l;
    int    bx;
    int    by;
    int    k;
    rect_t r;
    rect_t g;
    kind = $urandom_range(99);
    bx   = $urandom_range(0, 64000);
    by   = $urandom_range(0, 64000);
    r    = '{default: 0};
    page_gutters.delete();
    if (kind < 15) begin
      // noise: any op, full-range coordinates
      repeat ($urandom_range(3, 8)) begin
        r.x0 = $urandom_range(0, 65535);
        r.y0 = $urandom_range(0, 65535);
        r.x1 = $urandom_range(0, 65535);
        r.y1 = $urandom_range(0, 65535);
        send_req(2'($urandom_range(0, 3)), r);
      end
      if ($urandom_range(1) != 0) send_req(OP_EOP, r);
    end else begin
      // kind below 25 overfills the gutter table
      n_g = (kind < 25) ? DEF_MAX_GUTTERS + $urandom_range(1, 6) : $urandom_range(0, 8);
      n_l = (kind < 25) ? $urandom_range(2, 4) : $urandom_range(2, 12);
      repeat (n_g) begin
        g.x0 = bx + $urandom_range(0, 400);
        g.x1 = g.x0 + $urandom_range(2, 24);
        g.y0 = by + $urandom_range(0, 300);
        g.y1 = g.y0 + $urandom_range(20, 400);
        if ($urandom_range(19) == 0) g.x1 = g.x0;
        page_gutters.push_back(g);
        send_req(OP_LOAD, g);
      end
      repeat (n_l) begin
        if (page_gutters.size() != 0 && $urandom_range(2) == 0) begin
          // straddle the top or bottom edge of a loaded gutter at its center
          g    = page_gutters[$urandom_range(0, page_gutters.size() - 1)];
          k    = (g.x0 + g.x1) / 2;
          r.x0 = k - int'($urandom_range(0, 60));
          r.x1 = k + 1 + int'($urandom_range(0, 60));
          k    = ($urandom_range(1) != 0) ? g.y1 : g.y0;
          r.y0 = k - int'($urandom_range(0, 12));
          r.y1 = k + 1 + int'($urandom_range(0, 12));
        end else begin
          r.x0 = bx + $urandom_range(0, 450);
          r.x1 = r.x0 + $urandom_range(5, 200);
          r.y0 = by + $urandom_range(0, 700);
          r.y1 = r.y0 + $urandom_range(4, 30);
        end
        send_req(OP_LINE, r);
        if ($urandom_range(15) == 0) send_req(OP_LOAD, r);
      end
      send_req(OP_EOP, r);
    end
    pages++;
  endtask

  initial begin
    int unsigned goal;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SHRINK_X;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed page set at reset margins
    send_req(OP_EOP, rect_t'{0, 0, 0, 0});
    send_req(OP_UNUSED, rect_t'{65535, 65535, 65535, 65535});
    send_req(OP_LINE, rect_t'{0, 0, 65535, 65535});
    send_req(OP_EOP, rect_t'{0, 0, 0, 0});
    send_req(OP_LOAD, rect_t'{200, 50, 200, 300});
    send_req(OP_LOAD, rect_t'{100, 0, 110, 1000});
    send_req(OP_LINE, rect_t'{10, 500, 90, 520});
    send_req(OP_LINE, rect_t'{10, 480, 90, 500});
    send_req(OP_LINE, rect_t'{120, 480, 300, 500});
    send_req(OP_LINE, rect_t'{50, 990, 200, 1010});
    send_req(OP_LINE, rect_t'{95, 0, 115, 20});
    send_req(OP_LINE, rect_t'{400, 600, 500, 620});
    send_req(OP_LINE, rect_t'{5, 5, 12, 8});
    send_req(OP_LINE, rect_t'{3000, 3000, 3010, 3010});
    send_req(OP_UNUSED, rect_t'{0, 0, 65535, 65535});
    send_req(OP_EOP, rect_t'{0, 0, 0, 0});
    send_req(OP_LOAD, rect_t'{0, 0, 65535, 65535});
    send_req(OP_EOP, rect_t'{0, 0, 0, 0});
    send_req(OP_LINE, rect_t'{0, 0, 1, 1});
    send_req(OP_LINE, rect_t'{65534, 65534, 65535, 65535});
    send_req(OP_EOP, rect_t'{0, 0, 0, 0});
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_shrink(8'd0, 8'd0);
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
          write_shrink(8'd255, 8'd255);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
          write_shrink(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        3: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
          write_shrink(8'd255, 8'd0);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_shrink(SHRINK_X_RST, SHRINK_Y_RST);
        end
      endcase
      if (p == 0 || p == 3) holds_asked++;
      goal = reqs + PHASE_REQS;
      while (reqs < goal) random_page();
      drain();
    end

    $display("Sent %0d requests (%0d random pages); %0d columns checked, %0d closing a page.",
             reqs, pages, columns, page_ends);
    $display("Margins swept 0..255 under idle, stall and %0d-cycle hold-off mixes; %0d errors.",
             HOLD_CYCLES, errs);
    if (errs == 0) begin
      $display("PASS gutter_column_grouper");
    end else begin
      $display("FAIL gutter_column_grouper");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gcg_pkg.sv
rtl/core/gcg_ctrl.sv
rtl/core/gcg_datapath.sv
rtl/core/gutter_column_grouper.sv
tb/sv/gutter_column_grouper_checker.sv
tb/sv/gutter_column_grouper_tb.sv
